FILE: design/blinn_phong_point_shader_macros.svh
// assertion macros for the blinn-phong point shader checker
`ifndef BLINN_PHONG_POINT_SHADER_MACROS_SVH
`define BLINN_PHONG_POINT_SHADER_MACROS_SVH

// condition in one cycle implies a condition in the next
`define BPPS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

// condition implies a condition in the same cycle
`define BPPS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

FILE: design/bpps_pkg.sv
// shared widths, latencies, codes and types of the blinn-phong point shader
`timescale 1ns / 1ps
package bpps_pkg;
  localparam int unsigned Q_W        = 16;
  localparam int unsigned RAW_W      = 18;
  localparam int unsigned UNIT_W     = 17;
  localparam int unsigned MAG_W      = 17;
  localparam int unsigned SQ_W       = 2 * MAG_W;
  localparam int unsigned ROOT_IN_W  = 64;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 16;
  localparam int unsigned REM_W      = 48;
  localparam int unsigned FRAC_SH    = 30;
  localparam int unsigned NORM_LAT   = SQRT_STEPS + DIV_STEPS + 4;
  localparam int unsigned POW_STEPS  = 255;
  localparam int unsigned SHIN_W     = 8;
  localparam logic [Q_W-1:0] Q_ONE   = Q_W'(32768);

  typedef enum logic [2:0] {
    CFG_LIGHT_X   = 3'd0,
    CFG_LIGHT_Y   = 3'd1,
    CFG_LIGHT_Z   = 3'd2,
    CFG_DIFFUSE   = 3'd3,
    CFG_SPECULAR  = 3'd4,
    CFG_SHININESS = 3'd5
  } cfg_idx_e;

  typedef logic signed [RAW_W-1:0]  raw_vec_t [3];
  typedef logic signed [UNIT_W-1:0] unit_vec_t [3];

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;
endpackage

FILE: design/bpps_delay.sv
// enable-gated delay line that keeps side data level with the pipeline
`timescale 1ns / 1ps
module bpps_delay #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);
  logic [WIDTH-1:0] line_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) line_q[i] <= '0;
    end else if (en_i) begin
      line_q[0] <= data_i;
      for (int i = 1; i < DEPTH; i++) line_q[i] <= line_q[i-1];
    end
  end

  assign data_o = line_q[DEPTH-1];
endmodule

FILE: design/bpps_unit_vec.sv
// pipelined vector normaliser: squares, bit-per-stage root, bit-per-stage divide
`timescale 1ns / 1ps
module bpps_unit_vec import bpps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pipe_ctl_t ctl_i,
  input  raw_vec_t  vec_i,
  output logic      valid_o,
  output unit_vec_t vec_o
);
  logic             en;
  logic [MAG_W-1:0] mag_in [3];
  logic             v1_q;
  logic [MAG_W-1:0] mag1_q [3];
  logic             neg1_q [3];
  logic [SQ_W-1:0]  sq1_q [3];
  logic [SQ_W+1:0]  sum;

  logic                 sv_q   [SQRT_STEPS+1];
  logic [ROOT_IN_W-1:0] sn_q   [SQRT_STEPS+1];
  logic [ROOT_IN_W-1:0] sres_q [SQRT_STEPS+1];
  logic [MAG_W-1:0]     smag_q [SQRT_STEPS+1][3];
  logic                 sneg_q [SQRT_STEPS+1][3];
  logic                 szero_q [SQRT_STEPS+1];
  logic [ROOT_IN_W-1:0] sbit  [SQRT_STEPS];
  logic [ROOT_IN_W-1:0] trial [SQRT_STEPS];
  logic                 sge   [SQRT_STEPS];

  logic              dv_q    [DIV_STEPS+1];
  logic [REM_W-1:0]  drem_q  [DIV_STEPS+1][3];
  logic [Q_W-1:0]    dq_q    [DIV_STEPS+1][3];
  logic [ROOT_W-1:0] dr_q    [DIV_STEPS+1];
  logic              dneg_q  [DIV_STEPS+1][3];
  logic              dzero_q [DIV_STEPS+1];
  logic [REM_W-1:0]  dcmp [DIV_STEPS][3];
  logic              dge  [DIV_STEPS][3];

  logic      vo_q;
  unit_vec_t vo_d;
  unit_vec_t vec_q;

  assign en = ctl_i.en;

  always_comb begin
    logic signed [RAW_W-1:0] a;
    for (int c = 0; c < 3; c++) begin
      a = (vec_i[c] < 0) ? -vec_i[c] : vec_i[c];
      mag_in[c] = a[MAG_W-1:0];
    end
    sum = (SQ_W+2)'(sq1_q[0]) + (SQ_W+2)'(sq1_q[1]) + (SQ_W+2)'(sq1_q[2]);
  end

  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      sbit[k]  = ROOT_IN_W'(1) << (ROOT_IN_W - 2 - 2 * k);
      trial[k] = sres_q[k] + sbit[k];
      sge[k]   = sn_q[k] >= trial[k];
    end
    for (int j = 0; j < DIV_STEPS; j++) begin
      for (int c = 0; c < 3; c++) begin
        dcmp[j][c] = REM_W'(dr_q[j]) << (DIV_STEPS - 1 - j);
        dge[j][c]  = drem_q[j][c] >= dcmp[j][c];
      end
    end
  end

  always_comb begin
    logic [Q_W-1:0]    qc;
    logic [UNIT_W-1:0] u;
    for (int c = 0; c < 3; c++) begin
      qc = (dq_q[DIV_STEPS][c] > Q_ONE) ? Q_ONE : dq_q[DIV_STEPS][c];
      u  = {1'b0, qc};
      if (dzero_q[DIV_STEPS]) begin
        vo_d[c] = '0;
      end else if (dneg_q[DIV_STEPS][c]) begin
        vo_d[c] = -signed'(u);
      end else begin
        vo_d[c] = signed'(u);
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      for (int k = 0; k <= SQRT_STEPS; k++) sv_q[k] <= 1'b0;
      for (int j = 0; j <= DIV_STEPS; j++) dv_q[j] <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q    <= ctl_i.valid;
      sv_q[0] <= v1_q;
      for (int k = 0; k < SQRT_STEPS; k++) sv_q[k+1] <= sv_q[k];
      dv_q[0] <= sv_q[SQRT_STEPS];
      for (int j = 0; j < DIV_STEPS; j++) dv_q[j+1] <= dv_q[j];
      vo_q <= dv_q[DIV_STEPS];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        mag1_q[c] <= mag_in[c];
        neg1_q[c] <= vec_i[c] < 0;
        sq1_q[c]  <= SQ_W'(mag_in[c]) * SQ_W'(mag_in[c]);
      end
      sn_q[0]    <= {sum[SQ_W-1:0], {FRAC_SH{1'b0}}};
      sres_q[0]  <= '0;
      szero_q[0] <= sum == '0;
      for (int c = 0; c < 3; c++) begin
        smag_q[0][c] <= mag1_q[c];
        sneg_q[0][c] <= neg1_q[c];
      end
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sn_q[k+1]   <= sge[k] ? sn_q[k] - trial[k] : sn_q[k];
        sres_q[k+1] <= sge[k] ? (sres_q[k] >> 1) + sbit[k] : sres_q[k] >> 1;
        szero_q[k+1] <= szero_q[k];
        for (int c = 0; c < 3; c++) begin
          smag_q[k+1][c] <= smag_q[k][c];
          sneg_q[k+1][c] <= sneg_q[k][c];
        end
      end
      dr_q[0]    <= sres_q[SQRT_STEPS][ROOT_W-1:0];
      dzero_q[0] <= szero_q[SQRT_STEPS];
      for (int c = 0; c < 3; c++) begin
        drem_q[0][c] <= REM_W'({smag_q[SQRT_STEPS][c], {FRAC_SH{1'b0}}});
        dq_q[0][c]   <= '0;
        dneg_q[0][c] <= sneg_q[SQRT_STEPS][c];
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
        dr_q[j+1]    <= dr_q[j];
        dzero_q[j+1] <= dzero_q[j];
        for (int c = 0; c < 3; c++) begin
          drem_q[j+1][c] <= dge[j][c] ? drem_q[j][c] - dcmp[j][c] : drem_q[j][c];
          dq_q[j+1][c]   <= dge[j][c] ? dq_q[j][c] | (Q_W'(1) << (DIV_STEPS - 1 - j))
                                      : dq_q[j][c];
          dneg_q[j+1][c] <= dneg_q[j][c];
        end
      end
      vec_q <= vo_d;
    end
  end

  assign valid_o = vo_q;
  assign vec_o   = vec_q;
endmodule

FILE: design/blinn_phong_point_shader.sv
// blinn-phong shader top level, one point light, fully pipelined
//
//  channel | direction | handshake               | payload
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o   | point, normal, view, material
//  out     | out       | out_valid_o/out_ready_i | red_out_o, green_out_o, blue_out_o
//
// one item per cycle while the output is not stalled
// its depth is mainly two normaliser passes (32-step root, 16-step divide each)
// and the 255-stage exponent chain
// reset clears valid bits and loads the default light; cfg_ready_o is always high
// a stall on the output freezes every stage at once, nothing is lost or repeated
`timescale 1ns / 1ps
module blinn_phong_point_shader import bpps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic signed [15:0] point_z_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic signed [15:0] view_x_i,
  input  logic signed [15:0] view_y_i,
  input  logic signed [15:0] view_z_i,
  input  logic [47:0]        material_color_i,
  input  logic [47:0]        material_coefs_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        red_out_o,
  output logic [15:0]        green_out_o,
  output logic [15:0]        blue_out_o
);
  localparam int unsigned DOT_W   = 2 * UNIT_W + 2;
  localparam int unsigned MAT_W   = 96;
  localparam int unsigned ND_W    = 3 * UNIT_W + Q_W;
  localparam int unsigned MAT_LAT = 2 * NORM_LAT + POW_STEPS + 3;
  localparam int unsigned SUM_W   = 21;

  function automatic logic [Q_W-1:0] pos_cos(input logic signed [DOT_W-1:0] dot);
    logic signed [DOT_W-1:0] t;
    t = dot >>> 15;
    if (dot <= 0) return '0;
    if (t > DOT_W'(32768)) return Q_ONE;
    return t[Q_W-1:0];
  endfunction

  logic signed [15:0] light_x_q, light_y_q, light_z_q;
  logic [Q_W-1:0]     light_diff_q, light_spec_q;
  logic [SHIN_W-1:0]  shin_q;
  logic               en;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_x_q    <= 16'sd2560;
      light_y_q    <= -16'sd1280;
      light_z_q    <= 16'sd1280;
      light_diff_q <= Q_W'(32768);
      light_spec_q <= Q_W'(22938);
      shin_q       <= SHIN_W'(50);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LIGHT_X:   light_x_q    <= signed'(cfg_data_i);
        CFG_LIGHT_Y:   light_y_q    <= signed'(cfg_data_i);
        CFG_LIGHT_Z:   light_z_q    <= signed'(cfg_data_i);
        CFG_DIFFUSE:   light_diff_q <= cfg_data_i;
        CFG_SPECULAR:  light_spec_q <= cfg_data_i;
        CFG_SHININESS: shin_q       <= cfg_data_i[SHIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // input stage
  logic             v0_q;
  raw_vec_t         nraw_q, lraw_q, vraw_q;
  logic [MAT_W-1:0] mat0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nraw_q[0] <= RAW_W'(normal_x_i);
      nraw_q[1] <= RAW_W'(normal_y_i);
      nraw_q[2] <= RAW_W'(normal_z_i);
      lraw_q[0] <= RAW_W'(light_x_q) - RAW_W'(point_x_i);
      lraw_q[1] <= RAW_W'(light_y_q) - RAW_W'(point_y_i);
      lraw_q[2] <= RAW_W'(light_z_q) - RAW_W'(point_z_i);
      vraw_q[0] <= -RAW_W'(view_x_i);
      vraw_q[1] <= -RAW_W'(view_y_i);
      vraw_q[2] <= -RAW_W'(view_z_i);
      mat0_q    <= {material_color_i, material_coefs_i};
    end
  end

  // first normaliser pass
  unit_vec_t n1, l1, vu1;
  logic      vn1, vl1, vv1;

  bpps_unit_vec u_norm_n (
    .clk_i, .rst_ni, .ctl_i('{en: en, valid: v0_q}), .vec_i(nraw_q),
    .valid_o(vn1), .vec_o(n1)
  );
  bpps_unit_vec u_norm_l (
    .clk_i, .rst_ni, .ctl_i('{en: en, valid: v0_q}), .vec_i(lraw_q),
    .valid_o(vl1), .vec_o(l1)
  );
  bpps_unit_vec u_norm_v (
    .clk_i, .rst_ni, .ctl_i('{en: en, valid: v0_q}), .vec_i(vraw_q),
    .valid_o(vv1), .vec_o(vu1)
  );

  // half vector and diffuse products
  logic                    vh_q;
  raw_vec_t                hraw_q;
  unit_vec_t               nh_q;
  logic signed [2*UNIT_W-1:0] dprod_q [3];
  logic [Q_W-1:0]          d_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vh_q <= 1'b0;
    else if (en) vh_q <= vn1 & vl1 & vv1;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        hraw_q[c]  <= RAW_W'(l1[c]) + RAW_W'(vu1[c]);
        nh_q[c]    <= n1[c];
        dprod_q[c] <= l1[c] * n1[c];
      end
    end
  end

  assign d_h = pos_cos(DOT_W'(dprod_q[0]) + DOT_W'(dprod_q[1]) + DOT_W'(dprod_q[2]));

  unit_vec_t h2, n2;
  logic      vh2;
  logic [Q_W-1:0]  d2;
  logic [ND_W-1:0] nd_out;

  bpps_unit_vec u_norm_h (
    .clk_i, .rst_ni, .ctl_i('{en: en, valid: vh_q}), .vec_i(hraw_q),
    .valid_o(vh2), .vec_o(h2)
  );

  bpps_delay #(.WIDTH(ND_W), .DEPTH(NORM_LAT)) u_dly_nd (
    .clk_i, .rst_ni, .en_i(en),
    .data_i({nh_q[0], nh_q[1], nh_q[2], d_h}),
    .data_o(nd_out)
  );

  assign n2[0] = signed'(nd_out[ND_W-1 -: UNIT_W]);
  assign n2[1] = signed'(nd_out[ND_W-1-UNIT_W -: UNIT_W]);
  assign n2[2] = signed'(nd_out[Q_W +: UNIT_W]);
  assign d2    = nd_out[Q_W-1:0];

  // specular cosine
  logic                    vs_q;
  logic signed [2*UNIT_W-1:0] sprod_q [3];
  logic [Q_W-1:0]          ds_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vs_q <= 1'b0;
    else if (en) vs_q <= vh2;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) sprod_q[c] <= h2[c] * n2[c];
      ds_q <= d2;
    end
  end

  // exponent chain, one multiply per stage
  logic           cv_q [POW_STEPS+1];
  logic [Q_W-1:0] cs_q [POW_STEPS+1];
  logic [Q_W-1:0] cp_q [POW_STEPS+1];
  logic [Q_W-1:0] cd_q [POW_STEPS+1];
  logic [2*Q_W-1:0] cprod [POW_STEPS];

  always_comb begin
    for (int k = 0; k < POW_STEPS; k++) cprod[k] = (2*Q_W)'(cp_q[k]) * (2*Q_W)'(cs_q[k]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= POW_STEPS; k++) cv_q[k] <= 1'b0;
    end else if (en) begin
      cv_q[0] <= vs_q;
      for (int k = 0; k < POW_STEPS; k++) cv_q[k+1] <= cv_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cs_q[0] <= pos_cos(DOT_W'(sprod_q[0]) + DOT_W'(sprod_q[1]) + DOT_W'(sprod_q[2]));
      cp_q[0] <= Q_ONE;
      cd_q[0] <= ds_q;
      for (int k = 0; k < POW_STEPS; k++) begin
        cs_q[k+1] <= cs_q[k];
        cd_q[k+1] <= cd_q[k];
        cp_q[k+1] <= (SHIN_W'(k) < shin_q) ? cprod[k][2*Q_W-2:Q_W-1] : cp_q[k];
      end
    end
  end

  logic [MAT_W-1:0] mat_e;

  bpps_delay #(.WIDTH(MAT_W), .DEPTH(MAT_LAT)) u_dly_mat (
    .clk_i, .rst_ni, .en_i(en), .data_i(mat0_q), .data_o(mat_e)
  );

  // colour terms
  logic             ev1_q, ev2_q, ev3_q;
  logic [MAT_W-1:0] mat1_q, mat2_q;
  logic [16:0]      sp1_q, dm1_q;
  logic [17:0]      sp2_q, sp3_q, dl2_q;
  logic [16:0]      amb1_q [3];
  logic [16:0]      amb2_q [3];
  logic [16:0]      amb3_q [3];
  logic [18:0]      dc3_q [3];
  logic [31:0]      sp1_p, dm1_p;
  logic [31:0]      amb_p [3];
  logic [32:0]      sp2_p, dl2_p;
  logic [33:0]      dc_p [3];
  logic [Q_W-1:0]   col1 [3];
  logic [Q_W-1:0]   col2 [3];
  logic [SUM_W-1:0] chan_sum [3];
  logic [Q_W-1:0]   chan_d [3];
  logic [Q_W-1:0]   chan_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col1[c] = mat_e[MAT_W-1-Q_W*c -: Q_W];
      col2[c] = mat2_q[MAT_W-1-Q_W*c -: Q_W];
      amb_p[c] = 32'(mat_e[47:32]) * 32'(col1[c]);
      dc_p[c]  = 34'(dl2_q) * 34'(col2[c]);
      chan_sum[c] = SUM_W'(amb3_q[c]) + SUM_W'(dc3_q[c]) + SUM_W'(sp3_q);
      chan_d[c] = (chan_sum[c] > SUM_W'(Q_ONE)) ? Q_ONE : chan_sum[c][Q_W-1:0];
    end
    sp1_p = 32'(cp_q[POW_STEPS]) * 32'(light_spec_q);
    dm1_p = 32'(cd_q[POW_STEPS]) * 32'(mat_e[31:16]);
    sp2_p = 33'(sp1_q) * 33'(mat1_q[15:0]);
    dl2_p = 33'(dm1_q) * 33'(light_diff_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev1_q       <= 1'b0;
      ev2_q       <= 1'b0;
      ev3_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      ev1_q       <= cv_q[POW_STEPS];
      ev2_q       <= ev1_q;
      ev3_q       <= ev2_q;
      out_valid_q <= ev3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mat1_q <= mat_e;
      mat2_q <= mat1_q;
      sp1_q  <= sp1_p[31:15];
      dm1_q  <= dm1_p[31:15];
      sp2_q  <= sp2_p[32:15];
      dl2_q  <= dl2_p[32:15];
      sp3_q  <= sp2_q;
      for (int c = 0; c < 3; c++) begin
        amb1_q[c] <= amb_p[c][31:15];
        amb2_q[c] <= amb1_q[c];
        amb3_q[c] <= amb2_q[c];
        dc3_q[c]  <= dc_p[c][33:15];
        chan_q[c] <= chan_d[c];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = chan_q[0];
  assign green_out_o = chan_q[1];
  assign blue_out_o  = chan_q[2];
endmodule

FILE: design/bpps_checker.sv
// port-level checker for the blinn-phong point shader, bound to the top level
`timescale 1ns / 1ps
`include "blinn_phong_point_shader_macros.svh"
module bpps_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] red_out_o,
  input logic [15:0] green_out_o,
  input logic [15:0] blue_out_o
);
  // a stalled result stays put
  `BPPS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o), "result changed while stalled")

  // input side is ready exactly when the output register can move
  `BPPS_ASSERT_NOW(a_ready_link, in_valid_i || !in_valid_i, in_ready_o == (!out_valid_o || out_ready_i), "input ready does not follow output stall")

  // every channel saturates at one
  `BPPS_ASSERT_NOW(a_saturated, out_valid_o, red_out_o <= 16'd32768 && green_out_o <= 16'd32768 && blue_out_o <= 16'd32768, "channel above one")
endmodule

bind blinn_phong_point_shader bpps_checker u_bpps_checker (.*);

FILE: tb/sv/blinn_phong_point_shader_checker.sv
// shading predictor and result scoreboard for the blinn-phong point shader
`timescale 1ns / 1ps
module blinn_phong_point_shader_checker import bpps_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic signed [15:0] point_z_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic signed [15:0] view_x_i,
  input  logic signed [15:0] view_y_i,
  input  logic signed [15:0] view_z_i,
  input  logic [47:0]        material_color_i,
  input  logic [47:0]        material_coefs_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [15:0]        red_out_i,
  input  logic [15:0]        green_out_i,
  input  logic [15:0]        blue_out_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef longint vec3_t [3];
  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_t;

  logic signed [15:0] light_x, light_y, light_z;
  logic [15:0]        light_diff, light_spec;
  logic [7:0]         shine;
  rgb_t               colour_q [$];
  int                 fails;

  assign fail_count_o = fails;
  assign pending_o    = colour_q.size();

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic vec3_t to_unit(vec3_t v);
    vec3_t           u;
    longint unsigned mag [3];
    longint unsigned sum, r, q;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      sum += mag[i] * mag[i];
    end
    for (int i = 0; i < 3; i++) u[i] = 0;
    if (sum != 0) begin
      r = int_root(sum << 30);
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] << 30) / r;
        if (q > 32768) q = 32768;
        u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
    return u;
  endfunction

  function automatic longint unsigned clamped_cos(vec3_t a, vec3_t b);
    longint d;
    d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    if (d <= 0) return 0;
    d = d >>> 15;
    return (d > 32768) ? 32768 : d;
  endfunction

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b) >> 15;
  endfunction

  function automatic rgb_t shade_point();
    vec3_t           nraw, lraw, vraw, hraw, n, l, v, h;
    longint unsigned col [3];
    longint unsigned amb, mdiff, mspec, d, s, p, spec, c [3];
    rgb_t            res;
    nraw = '{longint'(normal_x_i), longint'(normal_y_i), longint'(normal_z_i)};
    lraw = '{longint'(light_x) - longint'(point_x_i), longint'(light_y) - longint'(point_y_i),
             longint'(light_z) - longint'(point_z_i)};
    vraw = '{-longint'(view_x_i), -longint'(view_y_i), -longint'(view_z_i)};
    n = to_unit(nraw);
    l = to_unit(lraw);
    v = to_unit(vraw);
    for (int k = 0; k < 3; k++) hraw[k] = l[k] + v[k];
    h = to_unit(hraw);
    col[0] = material_color_i[47:32];
    col[1] = material_color_i[31:16];
    col[2] = material_color_i[15:0];
    amb   = material_coefs_i[47:32];
    mdiff = material_coefs_i[31:16];
    mspec = material_coefs_i[15:0];
    d = clamped_cos(l, n);
    s = clamped_cos(h, n);
    p = 32768;
    for (int i = 0; i < shine; i++) p = qmul(p, s);
    spec = qmul(qmul(p, light_spec), mspec);
    for (int k = 0; k < 3; k++) begin
      c[k] = qmul(amb, col[k]) + qmul(qmul(qmul(d, mdiff), light_diff), col[k]) + spec;
      if (c[k] > 32768) c[k] = 32768;
    end
    res.red   = c[0][15:0];
    res.green = c[1][15:0];
    res.blue  = c[2][15:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t want;
    if (!rst_ni) begin
      light_x    <= 16'sd2560;
      light_y    <= -16'sd1280;
      light_z    <= 16'sd1280;
      light_diff <= 16'd32768;
      light_spec <= 16'd22938;
      shine      <= 8'd50;
      fails      = 0;
      colour_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LIGHT_X:   light_x    <= cfg_data_i;
          CFG_LIGHT_Y:   light_y    <= cfg_data_i;
          CFG_LIGHT_Z:   light_z    <= cfg_data_i;
          CFG_DIFFUSE:   light_diff <= cfg_data_i;
          CFG_SPECULAR:  light_spec <= cfg_data_i;
          CFG_SHININESS: shine      <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) colour_q.push_back(shade_point());
      if (out_valid_i && out_ready_i) begin
        if (colour_q.size() == 0) begin
          $display("result with nothing expected at %0t", $realtime);
          fails++;
        end else begin
          want = colour_q.pop_front();
          if (red_out_i !== want.red) report_mismatch("red", red_out_i, want.red);
          if (green_out_i !== want.green) report_mismatch("green", green_out_i, want.green);
          if (blue_out_i !== want.blue) report_mismatch("blue", blue_out_i, want.blue);
        end
      end
    end
  end

endmodule

FILE: tb/sv/blinn_phong_point_shader_test.sv
// stimulus, idling phases and verdict for the blinn-phong point shader
`timescale 1ns / 1ps
module blinn_phong_point_shader_test;
  import bpps_pkg::*;

  localparam int unsigned PIPE_DEPTH  = 366;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 900;
  localparam logic [2:0]  CFG_SPARE_A = 3'd6;
  localparam logic [2:0]  CFG_SPARE_B = 3'd7;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic signed [15:0] normal_x_i = '0, normal_y_i = '0, normal_z_i = '0;
  logic signed [15:0] view_x_i = '0, view_y_i = '0, view_z_i = '0;
  logic [47:0]        material_color_i = '0, material_coefs_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [15:0]        red_out_o, green_out_o, blue_out_o;

  int fail_count, pending;
  int send_idle_pct, recv_stall_pct;
  int hold_req = 0, hold_seen = 0, hold_left = 0;
  int quiet_cycles = 0, shaded = 0;

  always #2 clk_i = ~clk_i;

  blinn_phong_point_shader dut (.*);

  blinn_phong_point_shader_checker checker_inst (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .point_x_i, .point_y_i, .point_z_i,
    .normal_x_i, .normal_y_i, .normal_z_i, .view_x_i, .view_y_i, .view_z_i,
    .material_color_i, .material_coefs_i, .out_valid_i(out_valid_o), .out_ready_i,
    .red_out_i(red_out_o), .green_out_i(green_out_o), .blue_out_i(blue_out_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stalls plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      out_ready_i <= 1'b0;
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic send_item(logic [15:0] px, py, pz, nx, ny, nz, vx, vy, vz,
                           logic [47:0] colour, coefs);
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {point_x_i, point_y_i, point_z_i}    <= {px, py, pz};
    {normal_x_i, normal_y_i, normal_z_i} <= {nx, ny, nz};
    {view_x_i, view_y_i, view_z_i}       <= {vx, vy, vz};
    material_color_i <= colour;
    material_coefs_i <= coefs;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    shaded++;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom_range(5120)) - 16'd2560;
    endcase
  endfunction

  function automatic logic [47:0] rand_q15_triple();
    if ($urandom_range(4) == 0) return {16'($urandom), 32'($urandom)};
    return {16'($urandom_range(32768)), 16'($urandom_range(32768)),
            16'($urandom_range(32768))};
  endfunction

  task automatic send_random(int count);
    repeat (count) begin
      send_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                rand_q15_triple(), rand_q15_triple());
    end
  endtask

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edge cases under the reset light
    send_item(16'd100, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, -16'd256,
              {3{16'd32768}}, {3{16'd16384}});
    send_item(16'd2560, -16'd1280, 16'd1280, 16'd256, 16'd0, 16'd0, 16'd0, 16'd0, -16'd256,
              {3{16'd32768}}, {3{16'd32768}});
    send_item(16'd0, 16'd0, 16'd0, 16'd256, -16'd128, 16'd128, 16'd0, 16'd0, 16'd0,
              {3{16'd32768}}, {3{16'd32768}});
    send_item(16'd0, 16'd0, 16'd0, 16'd256, -16'd128, 16'd128, 16'd2560, -16'd1280, 16'd1280,
              {3{16'd32768}}, {3{16'd32768}});
    send_item(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
              16'h8000, 16'h8000, 16'h8000, {3{16'hffff}}, {3{16'hffff}});
    send_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
              16'h7fff, 16'h7fff, 16'h7fff, '0, '0);
    send_item(16'd0, 16'd0, 16'd0, 16'd2560, -16'd1280, 16'd1280, -16'd2560, 16'd1280,
              -16'd1280, {16'd32768, 16'd0, 16'd16384}, {16'd0, 16'd32768, 16'd32768});
    send_item(16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h0000, 16'h8000,
              16'h0001, 16'hffff, 16'h7fff, 48'hffff_0000_ffff, 48'h0000_ffff_0000);
    send_item(16'd256, 16'd256, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0, -16'd2560,
              48'h5555_aaaa_5555, 48'haaaa_5555_aaaa);
    send_item(16'd0, 16'd0, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0, 16'd256, 16'd0,
              {3{16'd20000}}, {3{16'd30000}});

    // full rate with a long output hold-off that backs the pipe up
    hold_req = hold_req + 1;
    send_random(500);
    drain_pipe();

    // extreme light, maximum exponent, sender idling
    write_reg(CFG_LIGHT_X, 16'h7fff);
    write_reg(CFG_LIGHT_Y, 16'h8000);
    write_reg(CFG_LIGHT_Z, 16'h0000);
    write_reg(CFG_DIFFUSE, 16'd0);
    write_reg(CFG_SPECULAR, 16'hffff);
    write_reg(CFG_SHININESS, 16'd255);
    send_idle_pct = 68;
    send_item(16'h7fff, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, -16'd256,
              {3{16'd32768}}, {3{16'd32768}});
    send_random(200);
    drain_pipe();

    // zero exponent, strong light, unused register indexes, receiver stalling
    write_reg(CFG_LIGHT_X, 16'd0);
    write_reg(CFG_LIGHT_Y, 16'd2560);
    write_reg(CFG_LIGHT_Z, -16'd2560);
    write_reg(CFG_DIFFUSE, 16'hffff);
    write_reg(CFG_SPECULAR, 16'd32768);
    write_reg(CFG_SHININESS, 16'd0);
    write_reg(CFG_SPARE_A, 16'h1234);
    write_reg(CFG_SPARE_B, 16'hffff);
    send_idle_pct = 0;
    recv_stall_pct = 68;
    send_random(220);
    drain_pipe();

    // random light, both sides idling
    write_reg(CFG_LIGHT_X, rand_coord());
    write_reg(CFG_LIGHT_Y, rand_coord());
    write_reg(CFG_LIGHT_Z, rand_coord());
    write_reg(CFG_DIFFUSE, 16'($urandom_range(32768)));
    write_reg(CFG_SPECULAR, 16'($urandom_range(32768)));
    write_reg(CFG_SHININESS, 16'($urandom_range(1, 64)));
    send_idle_pct = 32;
    recv_stall_pct = 32;
    send_random(220);
    drain_pipe();

    $display("shaded %0d points over four light settings and four idling phases,", shaded);
    $display("including zero vectors, zero and maximum exponent and a full-pipe stall");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/bpps_pkg.sv
design/bpps_delay.sv
design/bpps_unit_vec.sv
design/blinn_phong_point_shader.sv
design/bpps_checker.sv
tb/sv/blinn_phong_point_shader_checker.sv
tb/sv/blinn_phong_point_shader_test.sv
